// ===== sv/vas_pkg.sv =====
// Package with the transaction types, register indexes and timing constants of the alarm sequencer.
package vas_pkg;

    // Input transaction: one 1 ms tick.
    typedef struct packed {
        logic sensor_one_hit;
        logic sensor_two_hit;
        logic sensor_three_hit;
        logic lamp_requested;
    } t_in;

    // Output transaction: relay drives and the level report of one tick.
    typedef struct packed {
        logic       alarm_relay;
        logic       lamp_relay;
        logic       report_valid;
        logic [1:0] report_level;
    } t_out;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_PERIOD     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_WINDOW     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_TIME_FIRST  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_TIME_REPEAT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_OFF_TIME    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BURST_COUNT       = 3'd5;

    // Register reset values.
    localparam logic [15:0] RST_SAMPLE_PERIOD     = 16'd3000;
    localparam logic [23:0] RST_REPEAT_WINDOW     = 24'd60000;
    localparam logic [23:0] RST_ALARM_TIME_FIRST  = 24'd10000;
    localparam logic [23:0] RST_ALARM_TIME_REPEAT = 24'd30000;
    localparam logic [15:0] RST_FLASH_OFF_TIME    = 16'd200;
    localparam logic [7:0]  RST_BURST_COUNT       = 8'd3;

    // SOS timing in ticks.
    localparam logic [15:0] SHORT_ON_TICKS    = 16'd40;
    localparam logic [15:0] LONG_ON_TICKS     = 16'd250;
    localparam logic [15:0] BURST_GAP_TICKS   = 16'd1000;
    localparam logic [3:0]  FLASHES_PER_BURST = 4'd9;
    localparam logic [23:0] AGE_MAX           = 24'hFFFFFF;

    // Sequence phase codes.
    localparam logic [1:0] PH_OFF = 2'd0;
    localparam logic [1:0] PH_ON  = 2'd1;
    localparam logic [1:0] PH_GAP = 2'd2;

    // Lamp on time of a flash: flashes four to six are long.
    function automatic logic [15:0] f_on_time(input logic [3:0] idx);
        logic [15:0] t;
        t = ((idx >= 4'd3) && (idx <= 4'd5)) ? LONG_ON_TICKS : SHORT_ON_TICKS;
        return t;
    endfunction

endpackage

// ===== sv/vibration_alarm_sequencer_core.sv =====
// Vibration alarm sequencer: sensor sampling, lamp SOS sequence and alarm relay timing.
//
// Usage: each input transaction on i_in_* stands for one 1 ms tick and carries
// three sensor hit flags and the lamp state that software wants. Every
// accepted tick yields exactly one output transaction on o_out_* with the
// alarm relay and lamp relay drives and an optional sensor level report.
// The result of a tick is in the output register on the cycle after it is
// accepted. Throughput is one tick per cycle while o_in_stall is low; the whole tick
// update is one pass of counter logic into the state and output registers.
// The output register parts the two channels, so a new tick is taken while a
// result waits, as long as the receiver can take that result at the same edge.
// When the receiver stalls with a result pending, o_in_stall rises and the
// held result stays unchanged. Reset loads the register defaults, clears all
// sequencer state and empties the output register; the first tick samples.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while
// no tick is in flight.
module vibration_alarm_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  vas_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output vas_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_we,
    input  logic [vas_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [vas_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import vas_pkg::*;

    // Configuration registers.
    logic [15:0] r_sample_period;
    logic [23:0] r_repeat_window;
    logic [23:0] r_alarm_time_first;
    logic [23:0] r_alarm_time_repeat;
    logic [15:0] r_flash_off_time;
    logic [7:0]  r_burst_count;

    // Sequencer state.
    logic [2:0]  r_sensor_latch, n_sensor_latch;
    logic [15:0] r_sample_timer, n_sample_timer;
    logic [23:0] r_alarm_age,    n_alarm_age;
    logic        r_alarm_seen,   n_alarm_seen;
    logic [23:0] r_alarm_timer,  n_alarm_timer;
    logic        r_alarm_on,     n_alarm_on;
    logic        r_seq_active,   n_seq_active;
    logic [1:0]  r_seq_phase,    n_seq_phase;
    logic [3:0]  r_flash_index,  n_flash_index;
    logic [7:0]  r_burst_index,  n_burst_index;
    logic [15:0] r_seq_timer,    n_seq_timer;

    // Output register.
    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        in_accept;
    logic [15:0] flash_off_eff;
    logic [7:0]  burst_count_eff;
    logic [15:0] sample_period_eff;
    logic [23:0] time_first_eff;
    logic [23:0] time_repeat_eff;
    logic [1:0]  count;
    logic        repeat_alarm;
    logic [3:0]  flash_next;
    logic [7:0]  burst_next;

    // Handshake: take a tick unless a result is held back by the receiver.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Registers of zero act as one.
    assign flash_off_eff     = (r_flash_off_time == 16'd0) ? 16'd1 : r_flash_off_time;
    assign burst_count_eff   = (r_burst_count == 8'd0) ? 8'd1 : r_burst_count;
    assign sample_period_eff = (r_sample_period == 16'd0) ? 16'd1 : r_sample_period;
    assign time_first_eff    = (r_alarm_time_first == 24'd0) ? 24'd1 : r_alarm_time_first;
    assign time_repeat_eff   = (r_alarm_time_repeat == 24'd0) ? 24'd1 : r_alarm_time_repeat;

    // One tick of the sequencer, in the order latch, relay, age, sequence, sample.
    always_comb begin
        n_sensor_latch = r_sensor_latch | {i_in_data.sensor_three_hit,
                                           i_in_data.sensor_two_hit,
                                           i_in_data.sensor_one_hit};
        n_sample_timer = r_sample_timer;
        n_alarm_age    = r_alarm_age;
        n_alarm_seen   = r_alarm_seen;
        n_alarm_timer  = r_alarm_timer;
        n_alarm_on     = r_alarm_on;
        n_seq_active   = r_seq_active;
        n_seq_phase    = r_seq_phase;
        n_flash_index  = r_flash_index;
        n_burst_index  = r_burst_index;
        n_seq_timer    = r_seq_timer;
        count          = 2'd0;
        repeat_alarm   = 1'b0;
        flash_next     = r_flash_index + 4'd1;
        burst_next     = r_burst_index + 8'd1;
        n_out          = '0;

        // Relay on time counts down and ends the alarm at its last tick.
        if (r_alarm_on) begin
            if (r_alarm_timer <= 24'd1) begin
                n_alarm_on    = 1'b0;
                n_alarm_timer = 24'd0;
            end else begin
                n_alarm_timer = r_alarm_timer - 24'd1;
            end
        end

        // Age of the last alarm saturates.
        if (r_alarm_age != AGE_MAX) begin
            n_alarm_age = r_alarm_age + 24'd1;
        end

        // SOS sequence advance.
        if (r_seq_active) begin
            if (r_seq_timer > 16'd1) begin
                n_seq_timer = r_seq_timer - 16'd1;
            end else begin
                unique case (r_seq_phase)
                    PH_OFF: begin
                        if (r_flash_index < FLASHES_PER_BURST) begin
                            n_seq_phase = PH_ON;
                            n_seq_timer = f_on_time(r_flash_index);
                        end else begin
                            n_seq_active  = 1'b0;
                            n_seq_phase   = PH_OFF;
                            n_flash_index = 4'd0;
                            n_burst_index = 8'd0;
                            n_seq_timer   = 16'd0;
                        end
                    end
                    PH_ON: begin
                        n_seq_phase   = PH_OFF;
                        n_seq_timer   = flash_off_eff;
                        n_flash_index = flash_next;
                        if (flash_next >= FLASHES_PER_BURST) begin
                            n_flash_index = FLASHES_PER_BURST;
                            n_burst_index = burst_next;
                            // A burst that is not the last is followed by the long gap.
                            if ((burst_next < burst_count_eff) && (burst_next != 8'd0)) begin
                                n_seq_phase = PH_GAP;
                                n_seq_timer = BURST_GAP_TICKS;
                            end
                        end
                    end
                    default: begin
                        n_flash_index = 4'd0;
                        n_seq_phase   = PH_OFF;
                        n_seq_timer   = flash_off_eff;
                    end
                endcase
            end
        end

        // Sampling of the latched sensors.
        if (r_sample_timer == 16'd0) begin
            count = {1'b0, n_sensor_latch[0]} + {1'b0, n_sensor_latch[1]}
                  + {1'b0, n_sensor_latch[2]};
            n_sensor_latch = 3'd0;
            n_sample_timer = sample_period_eff - 16'd1;
            if (count != 2'd0) begin
                n_out.report_valid = 1'b1;
                n_out.report_level = count;
                // A warning starts the SOS sequence unless one already runs.
                if ((count >= 2'd2) && !n_seq_active) begin
                    n_seq_active  = 1'b1;
                    n_seq_phase   = PH_OFF;
                    n_flash_index = 4'd0;
                    n_burst_index = 8'd0;
                    n_seq_timer   = flash_off_eff;
                end
                // All three sensors switch the alarm relay on.
                if (count == 2'd3) begin
                    repeat_alarm  = r_alarm_seen && (n_alarm_age < r_repeat_window);
                    n_alarm_timer = repeat_alarm ? time_repeat_eff : time_first_eff;
                    n_alarm_on    = 1'b1;
                    n_alarm_seen  = 1'b1;
                    n_alarm_age   = 24'd0;
                end
            end
        end else begin
            n_sample_timer = r_sample_timer - 16'd1;
        end

        // Relay drives of this tick.
        n_out.alarm_relay = n_alarm_on;
        n_out.lamp_relay  = n_seq_active ? (n_seq_phase == PH_ON) : i_in_data.lamp_requested;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period     <= RST_SAMPLE_PERIOD;
            r_repeat_window     <= RST_REPEAT_WINDOW;
            r_alarm_time_first  <= RST_ALARM_TIME_FIRST;
            r_alarm_time_repeat <= RST_ALARM_TIME_REPEAT;
            r_flash_off_time    <= RST_FLASH_OFF_TIME;
            r_burst_count       <= RST_BURST_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_PERIOD:     r_sample_period     <= i_cfg_data[15:0];
                CFG_REPEAT_WINDOW:     r_repeat_window     <= i_cfg_data;
                CFG_ALARM_TIME_FIRST:  r_alarm_time_first  <= i_cfg_data;
                CFG_ALARM_TIME_REPEAT: r_alarm_time_repeat <= i_cfg_data;
                CFG_FLASH_OFF_TIME:    r_flash_off_time    <= i_cfg_data[15:0];
                CFG_BURST_COUNT:       r_burst_count       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_latch <= 3'd0;
            r_sample_timer <= 16'd0;
            r_alarm_age    <= 24'd0;
            r_alarm_seen   <= 1'b0;
            r_alarm_timer  <= 24'd0;
            r_alarm_on     <= 1'b0;
            r_seq_active   <= 1'b0;
            r_seq_phase    <= PH_OFF;
            r_flash_index  <= 4'd0;
            r_burst_index  <= 8'd0;
            r_seq_timer    <= 16'd0;
        end else if (in_accept) begin
            r_sensor_latch <= n_sensor_latch;
            r_sample_timer <= n_sample_timer;
            r_alarm_age    <= n_alarm_age;
            r_alarm_seen   <= n_alarm_seen;
            r_alarm_timer  <= n_alarm_timer;
            r_alarm_on     <= n_alarm_on;
            r_seq_active   <= n_seq_active;
            r_seq_phase    <= n_seq_phase;
            r_flash_index  <= n_flash_index;
            r_burst_index  <= n_burst_index;
            r_seq_timer    <= n_seq_timer;
        end
    end

    // Output register: loads on a new tick, empties when the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    // An idle relay never keeps a leftover on time.
    a_alarm_timer_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_alarm_on |-> (r_alarm_timer == 24'd0))
        else $error("alarm timer nonzero while relay is off");

    // An idle sequence holds its cleared position.
    a_seq_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seq_active |-> (r_seq_phase == PH_OFF) && (r_flash_index == 4'd0)
                          && (r_burst_index == 8'd0) && (r_seq_timer == 16'd0))
        else $error("sequence state not cleared while idle");

    // The burst gap only follows a complete burst.
    a_gap_after_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_active && (r_seq_phase == PH_GAP)) |-> (r_flash_index == FLASHES_PER_BURST))
        else $error("burst gap entered before the burst was complete");

    // A result without a report carries a zero level.
    a_level_without_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.report_valid) |-> (o_out_data.report_level == 2'd0))
        else $error("report level set without a report");

    // A tick that leaves the alarm on shows the relay on in its result.
    a_relay_follows_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_alarm_on) |=> (o_out_valid && o_out_data.alarm_relay))
        else $error("alarm relay output does not follow the alarm state");

endmodule

// ===== tb/sv/vibration_alarm_sequencer_checker.sv =====
// Checker for the alarm sequencer: watches both channels, predicts every tick and compares.
module vibration_alarm_sequencer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  vas_pkg::t_in                      i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  vas_pkg::t_out                     i_out_data,
    input  logic                              i_cfg_we,
    input  logic [vas_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [vas_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_mismatches,
    output int                                o_outstanding
);

    import vas_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the configuration registers.
    logic [15:0] period_ticks;
    logic [23:0] window_ticks;
    logic [23:0] first_ticks;
    logic [23:0] again_ticks;
    logic [15:0] dark_ticks;
    logic [7:0]  bursts_per_warning;

    // Shadow copy of the sequencer state.
    logic [2:0]  latched_hits;
    logic [15:0] sample_left;
    logic [23:0] alarm_age;
    logic        alarm_seen;
    logic [23:0] relay_left;
    logic        relay_on;
    logic        pattern_on;
    logic [1:0]  pattern_phase;
    logic [3:0]  flash_no;
    logic [7:0]  burst_no;
    logic [15:0] pattern_left;

    // Relay, lamp and report values still owed by the block, oldest first.
    t_out tick_results_due[$];
    int   mismatches;
    int   due_count;

    assign o_mismatches  = mismatches;
    assign o_outstanding = due_count;

    // A register value of zero behaves as one.
    function automatic logic [23:0] floor_one(input logic [23:0] v);
        return (v == 24'd0) ? 24'd1 : v;
    endfunction

    // Advance the sequencer by one tick and work out the output transaction it yields.
    task automatic step_sequencer(input t_in tick, output t_out res);
        logic [1:0] hits;
        logic       is_repeat;
        logic       into_gap;

        latched_hits = latched_hits |
                       {tick.sensor_three_hit, tick.sensor_two_hit, tick.sensor_one_hit};

        // Relay on time counts down; the relay drops when it runs out.
        if (relay_on) begin
            if (relay_left <= 24'd1) begin
                relay_on   = 1'b0;
                relay_left = 24'd0;
            end else begin
                relay_left = relay_left - 24'd1;
            end
        end
        if (alarm_age != AGE_MAX) begin
            alarm_age = alarm_age + 24'd1;
        end

        // SOS lamp pattern: off, flash, and a long pause between bursts.
        if (pattern_on) begin
            if (pattern_left > 16'd1) begin
                pattern_left = pattern_left - 16'd1;
            end else if (pattern_phase == PH_OFF) begin
                if (flash_no < FLASHES_PER_BURST) begin
                    pattern_phase = PH_ON;
                    pattern_left  = (flash_no >= 4'd3 && flash_no <= 4'd5) ?
                                    LONG_ON_TICKS : SHORT_ON_TICKS;
                end else begin
                    pattern_on    = 1'b0;
                    pattern_phase = PH_OFF;
                    flash_no      = 4'd0;
                    burst_no      = 8'd0;
                    pattern_left  = 16'd0;
                end
            end else if (pattern_phase == PH_ON) begin
                flash_no = flash_no + 4'd1;
                into_gap = 1'b0;
                if (flash_no >= FLASHES_PER_BURST) begin
                    flash_no = FLASHES_PER_BURST;
                    burst_no = burst_no + 8'd1;
                    into_gap = (24'(burst_no) < floor_one(24'(bursts_per_warning))) &&
                               (burst_no != 8'd0);
                end
                if (into_gap) begin
                    pattern_phase = PH_GAP;
                    pattern_left  = BURST_GAP_TICKS;
                end else begin
                    pattern_phase = PH_OFF;
                    pattern_left  = 16'(floor_one(24'(dark_ticks)));
                end
            end else begin
                flash_no      = 4'd0;
                pattern_phase = PH_OFF;
                pattern_left  = 16'(floor_one(24'(dark_ticks)));
            end
        end

        // Sample point: count the latched sensors, start the pattern and the alarm.
        hits = 2'd0;
        res  = '0;
        if (sample_left == 16'd0) begin
            hits = 2'(latched_hits[0]) + 2'(latched_hits[1]) + 2'(latched_hits[2]);
            latched_hits = 3'd0;
            sample_left  = 16'(floor_one(24'(period_ticks)) - 24'd1);
            if (hits != 2'd0) begin
                res.report_valid = 1'b1;
                if (hits >= 2'd2 && !pattern_on) begin
                    pattern_on    = 1'b1;
                    pattern_phase = PH_OFF;
                    flash_no      = 4'd0;
                    burst_no      = 8'd0;
                    pattern_left  = 16'(floor_one(24'(dark_ticks)));
                end
                if (hits == 2'd3) begin
                    is_repeat  = alarm_seen && (alarm_age < window_ticks);
                    relay_left = floor_one(is_repeat ? again_ticks : first_ticks);
                    relay_on   = 1'b1;
                    alarm_seen = 1'b1;
                    alarm_age  = 24'd0;
                end
            end
        end else begin
            sample_left = sample_left - 16'd1;
        end

        res.alarm_relay  = relay_on;
        res.lamp_relay   = pattern_on ? (pattern_phase == PH_ON) : tick.lamp_requested;
        res.report_level = hits;
    endtask

    // Track register writes, predict accepted ticks and compare accepted results.
    always @(posedge i_clk) begin : tick_monitor
        t_out predicted;
        t_out due;

        if (!i_rst_n) begin
            period_ticks       = RST_SAMPLE_PERIOD;
            window_ticks       = RST_REPEAT_WINDOW;
            first_ticks        = RST_ALARM_TIME_FIRST;
            again_ticks        = RST_ALARM_TIME_REPEAT;
            dark_ticks         = RST_FLASH_OFF_TIME;
            bursts_per_warning = RST_BURST_COUNT;
            latched_hits       = 3'd0;
            sample_left        = 16'd0;
            alarm_age          = 24'd0;
            alarm_seen         = 1'b0;
            relay_left         = 24'd0;
            relay_on           = 1'b0;
            pattern_on         = 1'b0;
            pattern_phase      = PH_OFF;
            flash_no           = 4'd0;
            burst_no           = 8'd0;
            pattern_left       = 16'd0;
            mismatches         = 0;
            tick_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD:     period_ticks       = i_cfg_data[15:0];
                    CFG_REPEAT_WINDOW:     window_ticks       = i_cfg_data;
                    CFG_ALARM_TIME_FIRST:  first_ticks        = i_cfg_data;
                    CFG_ALARM_TIME_REPEAT: again_ticks        = i_cfg_data;
                    CFG_FLASH_OFF_TIME:    dark_ticks         = i_cfg_data[15:0];
                    CFG_BURST_COUNT:       bursts_per_warning = i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // The result side is handled first, since a tick accepted at this
            // edge cannot have its result out at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("ERROR: result transaction with none expected: alarm=%0d",
                                 i_out_data.alarm_relay, " lamp=%0d valid=%0d level=%0d",
                                 i_out_data.lamp_relay, i_out_data.report_valid,
                                 i_out_data.report_level);
                    end
                end else begin
                    due = tick_results_due.pop_front();
                    if (due.alarm_relay !== i_out_data.alarm_relay ||
                        due.lamp_relay !== i_out_data.lamp_relay ||
                        due.report_valid !== i_out_data.report_valid ||
                        due.report_level !== i_out_data.report_level) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("ERROR: expected alarm=%0d lamp=%0d valid=%0d level=%0d,",
                                     due.alarm_relay, due.lamp_relay, due.report_valid,
                                     due.report_level,
                                     " got alarm=%0d lamp=%0d valid=%0d level=%0d",
                                     i_out_data.alarm_relay, i_out_data.lamp_relay,
                                     i_out_data.report_valid, i_out_data.report_level);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                step_sequencer(i_in_data, predicted);
                tick_results_due.push_back(predicted);
            end
        end
        due_count = tick_results_due.size();
    end

endmodule

// ===== tb/sv/vibration_alarm_sequencer_core_test.sv =====
// Testbench top for the alarm sequencer: clock, reset, tick stimulus, result stalls and verdict.
module vibration_alarm_sequencer_core_test;

    import vas_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int OPENING_COUNT  = 22;

    // Opening ticks as {sensor one, sensor two, sensor three, lamp}: single
    // sensors, two sensors starting the SOS pattern, three sensors raising a
    // first alarm while the pattern runs, then repeat alarms that restart the
    // relay while it is still on.
    localparam logic [3:0] OPENING_TICKS [OPENING_COUNT] = '{
        4'b0001, 4'b1000, 4'b0000, 4'b0100, 4'b0011, 4'b0001, 4'b1000, 4'b0010,
        4'b1101, 4'b0000, 4'b0000, 4'b1110, 4'b0001, 4'b0000, 4'b0001, 4'b0000,
        4'b0001, 4'b0110, 4'b0000, 4'b1111, 4'b0000, 4'b0001
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out                   o_out_data;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int mismatches;
    int outstanding;
    int quiet_run;
    bit idle_free;

    vibration_alarm_sequencer_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    vibration_alarm_sequencer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Clock with a period of 10.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pause length: mostly a few cycles, now and then a long one.
    function automatic int pick_pause();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(20, 60);
        end
        return $urandom_range(1, 3);
    endfunction

    // Random tick: each sensor fires with the given chance, with an
    // occasional shake that hits all three at once.
    function automatic t_in random_tick(input int hit_pct);
        t_in tick;
        tick.sensor_one_hit   = ($urandom_range(0, 99) < hit_pct);
        tick.sensor_two_hit   = ($urandom_range(0, 99) < hit_pct);
        tick.sensor_three_hit = ($urandom_range(0, 99) < hit_pct);
        tick.lamp_requested   = $urandom_range(0, 1);
        if ($urandom_range(0, 39) == 0) begin
            tick.sensor_one_hit   = 1'b1;
            tick.sensor_two_hit   = 1'b1;
            tick.sensor_three_hit = 1'b1;
        end
        return tick;
    endfunction

    // Offer one tick transaction and hold it until the block takes it.
    task automatic send_tick(input t_in tick);
        int gap;
        gap = (idle_free || $urandom_range(0, 1) == 0) ? 0 : pick_pause();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Let the block drain, then write all six registers.
    task automatic program_settings(input logic [15:0] period, input logic [23:0] window,
                                    input logic [23:0] first, input logic [23:0] again,
                                    input logic [15:0] dark, input logic [7:0] bursts);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        put_reg(CFG_SAMPLE_PERIOD, 24'(period));
        put_reg(CFG_REPEAT_WINDOW, window);
        put_reg(CFG_ALARM_TIME_FIRST, first);
        put_reg(CFG_ALARM_TIME_REPEAT, again);
        put_reg(CFG_FLASH_OFF_TIME, 24'(dark));
        put_reg(CFG_BURST_COUNT, 24'(bursts));
        i_cfg_we <= 1'b0;
    endtask

    // One setting of the registers followed by a run of random ticks.
    task automatic run_phase(input logic [15:0] period, input logic [23:0] window,
                             input logic [23:0] first, input logic [23:0] again,
                             input logic [15:0] dark, input logic [7:0] bursts,
                             input int ticks, input int hit_pct);
        program_settings(period, window, first, again, dark, bursts);
        for (int n = 0; n < ticks; n++) begin
            idle_free = ((n % 160) < 40);
            send_tick(random_tick(hit_pct));
        end
    endtask

    // Result side: random stalls, some long, none while idling is off.
    initial begin : result_sink
        int hold;
        bit stall_now;
        hold      = 0;
        stall_now = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                stall_now = !idle_free && ($urandom_range(0, 2) == 0);
                hold      = stall_now ? pick_pause() : $urandom_range(0, 4);
            end
            i_out_stall <= stall_now;
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_run <= 0;
        end else if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    // Main sequence: reset, opening ticks, then random phases over several settings.
    initial begin : stimulus
        quiet_run   = 0;
        idle_free   = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short sample period so the first sampled tick does not lock out later samples.
        program_settings(16'd2, 24'd30, 24'd5, 24'd12, 16'd1, 8'd1);
        for (int k = 0; k < OPENING_COUNT; k++) begin
            send_tick(t_in'(OPENING_TICKS[k]));
        end

        // Sample every tick, one-tick relay, no repeat window, one burst per warning.
        run_phase(16'd1, 24'd0, 24'd1, 24'd1, 16'd1, 8'd1, 200, 20);
        // Repeat window wide open and two bursts per warning.
        run_phase(16'd3, 24'hFFFFFF, 24'd7, 24'd20, 16'd3, 8'd2, 200, 12);
        // Zero in every register that treats zero as one.
        run_phase(16'd0, 24'd100, 24'd0, 24'd0, 16'd0, 8'd0, 80, 20);
        // Short window, so alarms fall both inside and outside it.
        run_phase(16'd5, 24'd40, 24'd3, 24'd9, 16'd2, 8'd255, 100, 25);
        // Largest values last, since they stall sampling and the pattern for good.
        run_phase(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 8'd255, 50, 25);

        // Drain and let a few more cycles pass for any stray result.
        i_in_valid <= 1'b0;
        idle_free = 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
